FILE: src/wne_pkg.sv
// Shared types and constants for the winding number edge accumulator.
package wne_pkg;

   localparam int COUNT_BITS = 16;
   localparam int OUT_BITS   = 16;
   localparam int COORD_BITS = 32;
   localparam int TOL_BITS   = 8;

   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUERY_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUERY_Y = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEAR_TOL = 2'd2;

   // One classified segment: what the back end must do to the counts.
   typedef struct packed {
      logic first;
      logic inc_on;
      logic wind;
      logic wind_dn;
      logic inc_vtx;
   } item_type;

endpackage

FILE: src/winding_number_edge_accumulator_core.sv
// A request passes through two front stages, the queue and the count register before
// its result is on the rsp_ ports.
// Throughput: one request per cycle while full is low; front and queue together hold
// at most 4 requests, plus one waiting in the result register.
// full rises once the queue plus the front's in-flight requests reach the queue depth.
// Reset (synchronous, active high): counts, queue, pipeline valids and query registers clear.
module winding_number_edge_accumulator_core (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       push,
   output logic                                       full,
   input  logic signed [wne_pkg::COORD_BITS-1:0]      req_start_x,
   input  logic signed [wne_pkg::COORD_BITS-1:0]      req_start_y,
   input  logic signed [wne_pkg::COORD_BITS-1:0]      req_end_x,
   input  logic signed [wne_pkg::COORD_BITS-1:0]      req_end_y,
   input  logic                                       req_first_of_path,
   output logic                                       empty,
   input  logic                                       pop,
   output logic signed [wne_pkg::OUT_BITS-1:0]        rsp_winding_total,
   output logic        [wne_pkg::OUT_BITS-1:0]        rsp_on_edge_total,
   output logic        [wne_pkg::OUT_BITS-1:0]        rsp_vertex_hit_total,
   input  logic                                       csr_we,
   input  logic [wne_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [wne_pkg::COORD_BITS-1:0]             csr_wdata
);
   import wne_pkg::*;

   logic signed [COORD_BITS-1:0] query_x_ff, query_y_ff;
   logic        [TOL_BITS-1:0]   near_tol_ff;

   logic                  accept;
   logic                  front_valid;
   item_type              front_item;
   logic [1:0]            front_busy;
   item_type              q_item;
   logic                  q_not_empty;
   logic [Q_CNT_BITS-1:0] q_count;
   logic                  q_take;
   logic                  rsp_valid;
   logic signed [COUNT_BITS-1:0] win_cnt;
   logic        [COUNT_BITS-1:0] on_cnt, vtx_cnt;
   logic signed [63:0]    win_wide;
   logic        [63:0]    on_wide, vtx_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         query_x_ff  <= '0;
         query_y_ff  <= '0;
         near_tol_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_QUERY_X:  query_x_ff  <= signed'(csr_wdata);
            CSR_QUERY_Y:  query_y_ff  <= signed'(csr_wdata);
            CSR_NEAR_TOL: near_tol_ff <= csr_wdata[TOL_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Reserve queue space for every request still in the front stages.
   assign full   = (32'(q_count) + 32'(front_busy)) >= Q_DEPTH;
   assign accept = push && !full;

   wne_classify u_classify (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .start_x       (req_start_x),
      .start_y       (req_start_y),
      .end_x         (req_end_x),
      .end_y         (req_end_y),
      .first_of_path (req_first_of_path),
      .query_x       (query_x_ff),
      .query_y       (query_y_ff),
      .near_tol      (near_tol_ff),
      .out_valid     (front_valid),
      .out_item      (front_item),
      .busy          (front_busy)
   );

   wne_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (front_valid),
      .push_item (front_item),
      .pop_en    (q_take),
      .pop_item  (q_item),
      .not_empty (q_not_empty),
      .count     (q_count)
   );

   wne_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_not_empty),
      .in_item    (q_item),
      .in_take    (q_take),
      .rsp_pop    (pop),
      .rsp_valid  (rsp_valid),
      .winding    (win_cnt),
      .on_edge    (on_cnt),
      .vertex_hit (vtx_cnt)
   );

   assign win_wide             = 64'(win_cnt);
   assign on_wide              = 64'(on_cnt);
   assign vtx_wide             = 64'(vtx_cnt);
   assign empty                = !rsp_valid;
   assign rsp_winding_total    = signed'(win_wide[OUT_BITS-1:0]);
   assign rsp_on_edge_total    = on_wide[OUT_BITS-1:0];
   assign rsp_vertex_hit_total = vtx_wide[OUT_BITS-1:0];

endmodule

FILE: src/wne_classify.sv
// Front end: segment differences, on-edge tests, cross product sign, classification.
module wne_classify (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [wne_pkg::COORD_BITS-1:0] start_x,
   input  logic signed [wne_pkg::COORD_BITS-1:0] start_y,
   input  logic signed [wne_pkg::COORD_BITS-1:0] end_x,
   input  logic signed [wne_pkg::COORD_BITS-1:0] end_y,
   input  logic                                  first_of_path,
   input  logic signed [wne_pkg::COORD_BITS-1:0] query_x,
   input  logic signed [wne_pkg::COORD_BITS-1:0] query_y,
   input  logic        [wne_pkg::TOL_BITS-1:0]   near_tol,
   output logic                                  out_valid,
   output wne_pkg::item_type                     out_item,
   output logic [1:0]                            busy
);
   import wne_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * COORD_BITS;

   typedef struct packed {
      logic skip;
      logic on_pre;
      logic end_pt;
      logic vtx;
      logic dn;
      logic first;
   } flags_type;

   // stage 1 next values
   logic signed [DW-1:0] dxe_in, dqy_in, dey_in, dqx_in;
   logic signed [DW-1:0] tol_s;
   flags_type            flags1_in;
   logic signed [COORD_BITS-1:0] ylo, yhi;
   logic betw, near_x, near_y;

   // stage 1 registers
   logic                 v1_ff;
   logic signed [DW-1:0] dxe_ff, dqy_ff, dey_ff, dqx_ff;
   flags_type            flags1_ff;

   // stage 2
   logic [COORD_BITS-1:0] mag_dxe, mag_dqy, mag_dey, mag_dqx;
   logic [PW-1:0]         mp_in, mq_in;
   logic                  pz_in, pn_in, qz_in, qn_in;
   logic                  v2_ff;
   logic [PW-1:0]         mp_ff, mq_ff;
   logic                  pz_ff, pn_ff, qz_ff, qn_ff;
   flags_type             flags2_ff;

   // stage 3 classification
   logic signed [1:0] sp, sq, cs;
   logic              mp_gt, mp_eq, left_cross;

   always_comb begin
      dxe_in = DW'(end_x) - DW'(start_x);
      dqy_in = DW'(query_y) - DW'(start_y);
      dey_in = DW'(end_y) - DW'(start_y);
      dqx_in = DW'(query_x) - DW'(start_x);
      tol_s  = signed'(DW'(near_tol));

      flags1_in.dn = start_y > end_y;
      ylo = flags1_in.dn ? end_y : start_y;
      yhi = flags1_in.dn ? start_y : end_y;
      flags1_in.skip = (query_y < ylo) || (query_y > yhi);

      betw = ((start_x <= query_x) && (query_x <= end_x)) ||
             ((end_x <= query_x) && (query_x <= start_x));
      near_x = (dqx_in >= -tol_s) && (dqx_in <= tol_s);
      near_y = (dqy_in >= -tol_s) && (dqy_in <= tol_s);
      if (start_y == end_y) begin
         flags1_in.on_pre = betw && (query_x != end_x);
      end else begin
         flags1_in.on_pre = near_x && near_y;
      end
      flags1_in.end_pt = (query_x == end_x) && (query_y == end_y);
      flags1_in.vtx    = query_y == start_y;
      flags1_in.first  = first_of_path;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      dxe_ff    <= dxe_in;
      dqy_ff    <= dqy_in;
      dey_ff    <= dey_in;
      dqx_ff    <= dqx_in;
      flags1_ff <= flags1_in;
   end

   // Differences stay below 2^32 in magnitude, so 32-bit magnitudes are exact.
   always_comb begin
      mag_dxe = dxe_ff[DW-1] ? COORD_BITS'(-dxe_ff) : dxe_ff[COORD_BITS-1:0];
      mag_dqy = dqy_ff[DW-1] ? COORD_BITS'(-dqy_ff) : dqy_ff[COORD_BITS-1:0];
      mag_dey = dey_ff[DW-1] ? COORD_BITS'(-dey_ff) : dey_ff[COORD_BITS-1:0];
      mag_dqx = dqx_ff[DW-1] ? COORD_BITS'(-dqx_ff) : dqx_ff[COORD_BITS-1:0];
      mp_in   = PW'(mag_dxe) * PW'(mag_dqy);
      mq_in   = PW'(mag_dey) * PW'(mag_dqx);
      pz_in   = (dxe_ff == '0) || (dqy_ff == '0);
      qz_in   = (dey_ff == '0) || (dqx_ff == '0);
      pn_in   = dxe_ff[DW-1] ^ dqy_ff[DW-1];
      qn_in   = dey_ff[DW-1] ^ dqx_ff[DW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      mp_ff     <= mp_in;
      mq_ff     <= mq_in;
      pz_ff     <= pz_in;
      pn_ff     <= pn_in;
      qz_ff     <= qz_in;
      qn_ff     <= qn_in;
      flags2_ff <= flags1_ff;
   end

   // Sign of the cross product from the signed magnitudes of both terms.
   always_comb begin
      sp    = pz_ff ? 2'sd0 : (pn_ff ? -2'sd1 : 2'sd1);
      sq    = qz_ff ? 2'sd0 : (qn_ff ? -2'sd1 : 2'sd1);
      mp_gt = mp_ff > mq_ff;
      mp_eq = mp_ff == mq_ff;
      if (sp != sq) begin
         cs = (sp > sq) ? 2'sd1 : -2'sd1;
      end else if ((sp == 2'sd0) || mp_eq) begin
         cs = 2'sd0;
      end else if (sp > 2'sd0) begin
         cs = mp_gt ? 2'sd1 : -2'sd1;
      end else begin
         cs = mp_gt ? -2'sd1 : 2'sd1;
      end
      // crossing counts only when the sign opposes the direction
      left_cross = flags2_ff.dn ? (cs > 2'sd0) : (cs < 2'sd0);

      out_item         = '0;
      out_item.first   = flags2_ff.first;
      if (!flags2_ff.skip) begin
         if (flags2_ff.on_pre) begin
            out_item.inc_on = 1'b1;
         end else if (cs == 2'sd0) begin
            out_item.inc_on = !flags2_ff.end_pt;
         end else if (left_cross) begin
            out_item.wind    = 1'b1;
            out_item.wind_dn = flags2_ff.dn;
            out_item.inc_vtx = flags2_ff.vtx;
         end
      end
   end

   assign out_valid = v2_ff;
   assign busy      = {1'b0, v1_ff} + {1'b0, v2_ff};

endmodule

FILE: src/wne_queue.sv
// Small register queue of classified requests between the front and back ends.
module wne_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push_en,
   input  wne_pkg::item_type               push_item,
   input  logic                            pop_en,
   output wne_pkg::item_type               pop_item,
   output logic                            not_empty,
   output logic [wne_pkg::Q_CNT_BITS-1:0]  count
);
   import wne_pkg::*;

   item_type               mem_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0]  count_ff, count_in;
   logic                   do_pop;

   assign do_pop = pop_en && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_en) begin
         wr_ptr_in = (32'(wr_ptr_ff) == Q_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == Q_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_en && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_en && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_en) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item  = mem_ff[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign count     = count_ff;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (32'(count_ff) == Q_DEPTH) |-> !push_en || do_pop)
      else $error("queue push while full");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= Q_DEPTH)
      else $error("queue count out of range");
`endif

endmodule

FILE: src/wne_accum.sv
// Back end: saturating winding, on-edge and vertex-hit counts; they are the result register.
module wne_accum (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  wne_pkg::item_type                     in_item,
   output logic                                  in_take,
   input  logic                                  rsp_pop,
   output logic                                  rsp_valid,
   output logic signed [wne_pkg::COUNT_BITS-1:0] winding,
   output logic        [wne_pkg::COUNT_BITS-1:0] on_edge,
   output logic        [wne_pkg::COUNT_BITS-1:0] vertex_hit
);
   import wne_pkg::*;

   localparam logic signed [COUNT_BITS-1:0] WIN_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
   localparam logic signed [COUNT_BITS-1:0] WIN_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
   localparam logic        [COUNT_BITS-1:0] CNT_MAX = '1;

   logic                         valid_ff, valid_in;
   logic signed [COUNT_BITS-1:0] win_ff, win_in, win_base;
   logic        [COUNT_BITS-1:0] on_ff, on_in, on_base;
   logic        [COUNT_BITS-1:0] vtx_ff, vtx_in, vtx_base;

   // Take a new request whenever the result slot is free or being drained.
   assign in_take = in_valid && (!valid_ff || rsp_pop);

   always_comb begin
      win_base = in_item.first ? '0 : win_ff;
      on_base  = in_item.first ? '0 : on_ff;
      vtx_base = in_item.first ? '0 : vtx_ff;
      win_in   = win_base;
      on_in    = on_base;
      vtx_in   = vtx_base;
      if (in_item.inc_on && (on_base != CNT_MAX)) begin
         on_in = on_base + 1'b1;
      end
      if (in_item.inc_vtx && (vtx_base != CNT_MAX)) begin
         vtx_in = vtx_base + 1'b1;
      end
      if (in_item.wind) begin
         if (in_item.wind_dn) begin
            if (win_base != WIN_MIN) begin
               win_in = win_base - 1'b1;
            end
         end else if (win_base != WIN_MAX) begin
            win_in = win_base + 1'b1;
         end
      end
      valid_in = in_take || (valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         win_ff   <= '0;
         on_ff    <= '0;
         vtx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         if (in_take) begin
            win_ff <= win_in;
            on_ff  <= on_in;
            vtx_ff <= vtx_in;
         end
      end
   end

   assign rsp_valid  = valid_ff;
   assign winding    = win_ff;
   assign on_edge    = on_ff;
   assign vertex_hit = vtx_ff;

`ifndef SYNTHESIS
   a_hold_counts: assert property (@(posedge clock) disable iff (reset)
      !in_take |=> $stable(win_ff) && $stable(on_ff) && $stable(vtx_ff))
      else $error("counts changed without a request");
   a_on_monotonic: assert property (@(posedge clock) disable iff (reset)
      in_take && !in_item.first |=> on_ff >= $past(on_ff))
      else $error("on-edge count decreased within a path");
`endif

endmodule
